/* design/gif_lzw_encoder_assert.svh */
// Assertion macros for the GIF LZW encoder
`ifndef GIF_LZW_ENCODER_ASSERT_SVH
`define GIF_LZW_ENCODER_ASSERT_SVH

// condition holds on the same edge
`define GLE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gif_lzw_encoder: check failed");

// condition holds on the following edge
`define GLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gif_lzw_encoder: check failed");

`endif

/* design/gle_pkg.sv */
// Types and constants shared across the GIF LZW encoder
package gle_pkg;

  localparam int DICT_ENTRIES   = 4096;
  localparam int MAX_CODE_WIDTH = 12;
  localparam int DICT_LIMIT_I   = (DICT_ENTRIES < (1 << MAX_CODE_WIDTH)) ?
                                  DICT_ENTRIES : (1 << MAX_CODE_WIDTH);
  localparam int ADDR_W         = $clog2(DICT_ENTRIES);
  localparam int FREE_W         = ADDR_W + 1;
  localparam int CODE_W         = 12;
  localparam int ENTRY_W        = CODE_W + 8;
  localparam int ACC_W          = CODE_W + 7;
  localparam int CNT_W          = 5;

  localparam logic [FREE_W-1:0] DICT_LIMIT = FREE_W'(DICT_LIMIT_I);
  localparam logic [3:0]        WIDTH_CAP  = 4'(MAX_CODE_WIDTH);

  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_PIXEL  = 2'd1;
  localparam logic [1:0] FUNC_FINISH = 2'd2;

  localparam logic [3:0] ROOT_RESET = 4'd8;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       stream_end;
  } out_item_t;

  // sequencer to bit packer
  typedef struct packed {
    logic              clr;
    logic              load;
    logic [CODE_W-1:0] code;
    logic [3:0]        width;
    logic              end_req;
    logic              fin;
  } pk_cmd_t;

endpackage

/* design/gle_ram.sv */
// Generic single write port RAM with registered read
module gle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/gle_packer.sv */
// LSB-first bit packer with one-byte hold and output register
module gle_packer (
  input  logic               clk,
  input  logic               rst_n,
  input  gle_pkg::pk_cmd_t   cmd,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_stall,
  output gle_pkg::out_item_t out_data
);
  import gle_pkg::*;

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic             held_vld_r, held_vld_nxt;
  logic [7:0]       held_r, held_nxt;
  logic             end_r, end_nxt;
  logic             fin_r, fin_nxt;
  logic             ov_r, ov_nxt;
  out_item_t        od_r, od_nxt;
  logic             out_free;
  logic             step_byte;

  assign out_free  = !ov_r || !out_stall;
  assign step_byte = (n_r >= CNT_W'(8)) || (end_r && fin_r && (n_r != '0));
  assign busy      = (n_r >= CNT_W'(8)) || end_r;

  always_comb begin
    acc_nxt      = acc_r;
    n_nxt        = n_r;
    held_vld_nxt = held_vld_r;
    held_nxt     = held_r;
    end_nxt      = end_r;
    fin_nxt      = fin_r;
    ov_nxt       = ov_r && out_stall;
    od_nxt       = od_r;
    if (cmd.clr) begin
      acc_nxt = '0;
      n_nxt   = '0;
    end else if (cmd.load) begin
      acc_nxt = acc_r | (ACC_W'(cmd.code) << n_r);
      n_nxt   = n_r + CNT_W'(cmd.width);
    end else if (cmd.end_req) begin
      end_nxt = 1'b1;
      fin_nxt = cmd.fin;
    end else if (step_byte) begin
      if (!held_vld_r || out_free) begin
        if (held_vld_r) begin
          ov_nxt = 1'b1;
          od_nxt = '{out_byte: held_r, out_last: 1'b0, stream_end: 1'b0};
        end
        held_nxt     = acc_r[7:0];
        held_vld_nxt = 1'b1;
        acc_nxt      = acc_r >> 8;
        n_nxt        = (n_r >= CNT_W'(8)) ? n_r - CNT_W'(8) : '0;
      end
    end else if (end_r) begin
      // release the held byte as the last one of the request
      if (!held_vld_r) begin
        end_nxt = 1'b0;
      end else if (out_free) begin
        ov_nxt       = 1'b1;
        od_nxt       = '{out_byte: held_r, out_last: 1'b1, stream_end: fin_r};
        held_vld_nxt = 1'b0;
        end_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      n_r        <= '0;
      held_vld_r <= 1'b0;
      end_r      <= 1'b0;
      fin_r      <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      acc_r      <= acc_nxt;
      n_r        <= n_nxt;
      held_vld_r <= held_vld_nxt;
      end_r      <= end_nxt;
      fin_r      <= fin_nxt;
      ov_r       <= ov_nxt;
    end
    held_r <= held_nxt;
    od_r   <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

/* design/gif_lzw_encoder.sv */
// GIF LZW encoder top level: sequencer, dictionary search and packer
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall  in_item_t (func, pixel)
//  out_     output     out_valid/out_stall out_item_t (byte, last, stream_end)
//  cfg_     input      cfg_valid/cfg_ready root_bits (4 bits)
//
// A pixel that opens a string, or a reserved request, is taken at once. Otherwise the
// dictionary is walked linearly from the first code after end-of-information (RAM read
// then compare per entry) until a hit or a miss; a miss sends the code and adds an entry,
// followed by the clear code when the table fills. Requests that send codes wait on the
// packer's drain, one byte per cycle unless stalled. in_stall is high while a request is
// being worked; output stalls hold packer and sequencer. No clearing pass after reset.
module gif_lzw_encoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gle_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gle_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data
);
  import gle_pkg::*;

  `include "gif_lzw_encoder_assert.svh"

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_CMP  = 8'b0000_0100,
    S_SEND = 8'b0000_1000,
    S_UPD  = 8'b0001_0000,
    S_CLR  = 8'b0010_0000,
    S_FIN2 = 8'b0100_0000,
    S_END  = 8'b1000_0000
  } state_t;

  state_t            st_r, st_nxt, ret_r, ret_nxt;
  logic              wait_r, wait_nxt;
  logic [3:0]        root_r;
  logic [3:0]        cw_r, cw_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;
  logic [FREE_W-1:0] idx_r, idx_nxt;
  logic [CODE_W-1:0] cur_r, cur_nxt;
  logic              sv_r, sv_nxt;
  logic [7:0]        pix_r, pix_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              fin_r, fin_nxt;

  logic [3:0]        r_eff;
  logic [8:0]        clr_sym;
  logic [FREE_W-1:0] first;
  logic [7:0]        k;
  logic [3:0]        w_eff;
  logic [12:0]       w_mask;
  logic [FREE_W-1:0] free_inc;
  logic [FREE_W-1:0] idx_inc;
  logic              accept;

  logic               ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  pk_cmd_t            pk_cmd;
  logic               pk_busy;

  assign r_eff      = (root_r < 4'd2) ? 4'd2 : ((root_r > 4'd8) ? 4'd8 : root_r);
  assign clr_sym    = 9'd1 << r_eff;
  assign first      = FREE_W'(clr_sym) + FREE_W'(2);
  assign k          = in_data.pixel & 8'(clr_sym - 9'd1);
  assign w_eff      = (cw_r > WIDTH_CAP) ? WIDTH_CAP : cw_r;
  assign w_mask     = (13'd1 << w_eff) - 13'd1;
  assign free_inc   = free_r + FREE_W'(1);
  assign idx_inc    = idx_r + FREE_W'(1);

  assign in_stall  = (st_r != S_IDLE) || wait_r;
  assign cfg_ready = (st_r == S_IDLE) && !wait_r;
  assign accept    = in_valid && !in_stall;
  assign ram_we    = (st_r == S_UPD) && (free_r < DICT_LIMIT);

  always_comb begin
    st_nxt   = st_r;
    ret_nxt  = ret_r;
    wait_nxt = wait_r;
    cw_nxt   = cw_r;
    free_nxt = free_r;
    idx_nxt  = idx_r;
    cur_nxt  = cur_r;
    sv_nxt   = sv_r;
    pix_nxt  = pix_r;
    code_nxt = code_r;
    fin_nxt  = fin_r;
    pk_cmd   = '0;
    pk_cmd.code  = code_r & w_mask[CODE_W-1:0];
    pk_cmd.width = w_eff;
    pk_cmd.fin   = fin_r;
    unique case (st_r)
      S_IDLE: begin
        if (wait_r) begin
          if (!pk_busy) wait_nxt = 1'b0;
        end else if (accept) begin
          fin_nxt = 1'b0;
          pix_nxt = k;
          unique case (in_data.func)
            FUNC_START: begin
              pk_cmd.clr = 1'b1;
              free_nxt   = first;
              cw_nxt     = r_eff + 4'd1;
              sv_nxt     = 1'b0;
              cur_nxt    = '0;
              code_nxt   = CODE_W'(clr_sym);
              ret_nxt    = S_END;
              st_nxt     = S_SEND;
            end
            FUNC_PIXEL: begin
              if (!sv_r) begin
                cur_nxt = CODE_W'(k);
                sv_nxt  = 1'b1;
              end else if (first >= free_r) begin
                code_nxt = cur_r;
                ret_nxt  = S_UPD;
                st_nxt   = S_SEND;
              end else begin
                idx_nxt = first;
                st_nxt  = S_RD;
              end
            end
            FUNC_FINISH: begin
              fin_nxt = 1'b1;
              if (sv_r) begin
                code_nxt = cur_r;
                sv_nxt   = 1'b0;
                ret_nxt  = S_FIN2;
                st_nxt   = S_SEND;
              end else begin
                st_nxt = S_FIN2;
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: st_nxt = S_CMP;
      S_CMP: begin
        if (ram_rdata == {cur_r, pix_r}) begin
          cur_nxt = CODE_W'(idx_r);
          st_nxt  = S_IDLE;
        end else if (idx_inc >= free_r) begin
          code_nxt = cur_r;
          ret_nxt  = S_UPD;
          st_nxt   = S_SEND;
        end else begin
          idx_nxt = idx_inc;
          st_nxt  = S_RD;
        end
      end
      S_SEND: begin
        if (!pk_busy) begin
          pk_cmd.load = 1'b1;
          st_nxt      = ret_r;
        end
      end
      S_UPD: begin
        cur_nxt = CODE_W'(pix_r);
        sv_nxt  = 1'b1;
        st_nxt  = S_END;
        if (free_r < DICT_LIMIT) begin
          free_nxt = free_inc;
          if ((16'(free_inc) >= (16'd1 << cw_r)) && (cw_r < WIDTH_CAP)) begin
            cw_nxt = cw_r + 4'd1;
          end
          if (free_inc >= DICT_LIMIT) begin
            code_nxt = CODE_W'(clr_sym);
            ret_nxt  = S_CLR;
            st_nxt   = S_SEND;
          end
        end
      end
      S_CLR: begin
        free_nxt = first;
        cw_nxt   = r_eff + 4'd1;
        st_nxt   = S_END;
      end
      S_FIN2: begin
        code_nxt = CODE_W'(clr_sym) + CODE_W'(1);
        ret_nxt  = S_END;
        st_nxt   = S_SEND;
      end
      S_END: begin
        if (!pk_busy) begin
          pk_cmd.end_req = 1'b1;
          wait_nxt       = 1'b1;
          st_nxt         = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ret_r  <= S_IDLE;
      wait_r <= 1'b0;
      root_r <= ROOT_RESET;
      cw_r   <= ROOT_RESET + 4'd1;
      free_r <= FREE_W'((1 << 8) + 2);
      cur_r  <= '0;
      sv_r   <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ret_r  <= ret_nxt;
      wait_r <= wait_nxt;
      if (cfg_valid && cfg_ready) root_r <= cfg_data;
      cw_r   <= cw_nxt;
      free_r <= free_nxt;
      cur_r  <= cur_nxt;
      sv_r   <= sv_nxt;
      fin_r  <= fin_nxt;
    end
    idx_r  <= idx_nxt;
    pix_r  <= pix_nxt;
    code_r <= code_nxt;
  end

  gle_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DICT_ENTRIES)
  ) u_dict (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_r[ADDR_W-1:0]),
    .wdata ({cur_r, pix_r}),
    .raddr (idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  gle_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (pk_cmd),
    .busy      (pk_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `GLE_ASSERT_IMPL(a_idle_packer_quiet, accept, !pk_busy)
  `GLE_ASSERT_IMPL(a_width_cap, 1'b1, cw_r <= WIDTH_CAP)
  `GLE_ASSERT_IMPL(a_free_bound, 1'b1, free_r <= DICT_LIMIT)
  `GLE_ASSERT_NEXT(a_hit_returns_idle, (st_r == S_CMP) && (ram_rdata == {cur_r, pix_r}),
                   st_r == S_IDLE)

endmodule

/* dv/gif_lzw_encoder_tb.sv */
// Self-checking testbench for the GIF LZW encoder: directed table, then random streams
`timescale 1ns / 100ps

module gif_lzw_encoder_tb;
  import gle_pkg::*;

  localparam logic [1:0] FUNC_RSVD = 2'd3;

  typedef struct {
    in_item_t  item;
    bit        typed;
    int        n;
    out_item_t e [4];
  } step_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [3:0] cfg_data;

  gif_lzw_encoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // encoder model state
  logic [11:0] dict_pre [DICT_ENTRIES];
  logic [7:0]  dict_suf [DICT_ENTRIES];
  int unsigned next_free, cw, cur_str, pend_bits, pend_cnt;
  bit          str_live;
  logic [3:0]  root_reg;

  out_item_t   byte_q [$];
  step_row_t   row_q [$];
  out_item_t   gen_b [4];
  int          gen_n;
  int          errors;
  bit          quiet, long_hold;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int unsigned root_eff();
    int unsigned r;
    r = root_reg;
    if (r < 2) r = 2;
    if (r > 8) r = 8;
    return r;
  endfunction

  function automatic void restart_dict();
    next_free = (1 << root_eff()) + 2;
    cw        = root_eff() + 1;
    str_live  = 1'b0;
    cur_str   = 0;
  endfunction

  function automatic void pack_code(int unsigned code);
    int unsigned w, acc, n;
    w = (cw > 12) ? 12 : cw;
    code &= (1 << w) - 1;
    acc = pend_bits | (code << pend_cnt);
    n = pend_cnt + w;
    while (n >= 8) begin
      if (gen_n < 4) begin
        gen_b[gen_n] = '{out_byte: acc[7:0], out_last: 1'b0, stream_end: 1'b0};
        gen_n++;
      end
      acc >>= 8;
      n -= 8;
    end
    pend_bits = acc & 'h7F;
    pend_cnt  = n;
  endfunction

  // encode one request, results land in gen_b/gen_n
  function automatic void encode(in_item_t it);
    int unsigned clr, k, i, lo, hi;
    bit hit;
    clr = 1 << root_eff();
    gen_n = 0;
    case (it.func)
      FUNC_START: begin
        pend_bits = 0;
        pend_cnt  = 0;
        restart_dict();
        pack_code(clr);
      end
      FUNC_PIXEL: begin
        k = it.pixel & (clr - 1);
        if (!str_live) begin
          cur_str  = k;
          str_live = 1'b1;
        end else begin
          hit = 1'b0;
          lo  = clr + 2;
          hi  = (next_free < DICT_ENTRIES) ? next_free : DICT_ENTRIES;
          for (i = lo; i < hi && !hit; i++)
            if (dict_pre[i] == cur_str[11:0] && dict_suf[i] == k[7:0]) begin
              hit = 1'b1;
              cur_str = i;
            end
          if (!hit) begin
            pack_code(cur_str);
            if (next_free < DICT_LIMIT_I) begin
              dict_pre[next_free] = cur_str[11:0];
              dict_suf[next_free] = k[7:0];
              next_free++;
              if (next_free >= (1 << cw) && cw < MAX_CODE_WIDTH) cw++;
              if (next_free >= DICT_LIMIT_I) begin
                pack_code(clr);
                restart_dict();
              end
            end
            cur_str  = k;
            str_live = 1'b1;
          end
        end
      end
      FUNC_FINISH: begin
        if (str_live) begin
          pack_code(cur_str);
          str_live = 1'b0;
        end
        pack_code(clr + 1);
        if (pend_cnt > 0 && gen_n < 4) begin
          gen_b[gen_n] = '{out_byte: 8'(pend_bits), out_last: 1'b0, stream_end: 1'b0};
          gen_n++;
        end
        if (pend_cnt > 0) begin
          pend_bits = 0;
          pend_cnt  = 0;
        end
        if (gen_n > 0) gen_b[gen_n-1].stream_end = 1'b1;
      end
      default: ;
    endcase
    if (gen_n > 0) gen_b[gen_n-1].out_last = 1'b1;
  endfunction

  // sample both channels at the edge (pre-update values)
  always @(posedge clk) begin
    step_row_t r;
    out_item_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) root_reg <= cfg_data;
      if (in_valid && !in_stall) begin
        r = row_q.pop_front();
        encode(in_data);
        if (r.typed) for (int i = 0; i < r.n; i++) byte_q.push_back(r.e[i]);
        else for (int i = 0; i < gen_n; i++) byte_q.push_back(gen_b[i]);
      end
      if (out_valid && !out_stall) begin
        if (byte_q.size() == 0) begin
          $display("%0t: unexpected byte, expected none, actual %h/%b/%b", $time,
                   out_data.out_byte, out_data.out_last, out_data.stream_end);
          errors++;
        end else begin
          want = byte_q.pop_front();
          if (out_data !== want) begin
            $display("%0t: byte mismatch, expected %h/%b/%b, actual %h/%b/%b", $time,
                     want.out_byte, want.out_last, want.stream_end,
                     out_data.out_byte, out_data.out_last, out_data.stream_end);
            errors++;
          end
        end
      end
    end
  end

  // receiver side
  initial begin
    out_stall <= 1'b0;
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  task automatic send(in_item_t it, bit typed = 0, int n = 0,
                      out_item_t e0 = '0, out_item_t e1 = '0);
    step_row_t r;
    r.item  = it;
    r.typed = typed;
    r.n     = n;
    r.e[0]  = e0;
    r.e[1]  = e1;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    row_q.push_back(r);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (byte_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_root(logic [3:0] v);
    drain();
    // a trailing pixel may still be searching with no byte to show for it
    repeat (2 * next_free + 40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  task automatic rand_stream(int len, bit skip_start);
    in_item_t it;
    if (!skip_start) send('{func: FUNC_START, pixel: 8'($urandom_range(0, 255))});
    for (int i = 0; i < len; i++) begin
      it.func  = FUNC_PIXEL;
      it.pixel = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3))
                                             : 8'($urandom_range(0, 255));
      if ($urandom_range(0, 24) == 0) it.func = FUNC_RSVD;
      send(it);
    end
    if ($urandom_range(0, 7) != 0) send('{func: FUNC_FINISH, pixel: 8'($urandom_range(0, 255))});
  endtask

  initial begin
    logic [3:0] roots [10];
    step_row_t tbl [12];
    roots     = '{4'd2, 4'd0, 4'd15, 4'd5, 4'd3, 4'd1, 4'd9, 4'd7, 4'd4, 4'd8};
    errors    = 0;
    quiet     = 1'b0;
    long_hold = 1'b0;
    root_reg  = ROOT_RESET;
    pend_bits = 0;
    pend_cnt  = 0;
    foreach (dict_pre[i]) begin
      dict_pre[i] = '0;
      dict_suf[i] = '0;
    end
    restart_dict();

    tbl[0]  = '{'{FUNC_PIXEL, 8'h80}, 0, 0, '{default: '0}};
    tbl[1]  = '{'{FUNC_START, 8'h00}, 1, 1, '{'{8'h00, 1'b1, 1'b0}, '0, '0, '0}};
    tbl[2]  = '{'{FUNC_FINISH, 8'h00}, 1, 2,
                '{'{8'h03, 1'b0, 1'b0}, '{8'h02, 1'b1, 1'b1}, '0, '0}};
    tbl[3]  = '{'{FUNC_START, 8'hFF}, 1, 1, '{'{8'h00, 1'b1, 1'b0}, '0, '0, '0}};
    tbl[4]  = '{'{FUNC_PIXEL, 8'hFF}, 1, 0, '{default: '0}};
    tbl[5]  = '{'{FUNC_PIXEL, 8'hFF}, 1, 1, '{'{8'hFF, 1'b1, 1'b0}, '0, '0, '0}};
    tbl[6]  = '{'{FUNC_PIXEL, 8'hFF}, 0, 0, '{default: '0}};
    tbl[7]  = '{'{FUNC_PIXEL, 8'h00}, 0, 0, '{default: '0}};
    tbl[8]  = '{'{FUNC_RSVD, 8'hFF}, 1, 0, '{default: '0}};
    tbl[9]  = '{'{FUNC_PIXEL, 8'h00}, 0, 0, '{default: '0}};
    tbl[10] = '{'{FUNC_PIXEL, 8'h00}, 0, 0, '{default: '0}};
    tbl[11] = '{'{FUNC_FINISH, 8'h55}, 0, 0, '{default: '0}};

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (tbl[i]) send(tbl[i].item, tbl[i].typed, tbl[i].n, tbl[i].e[0], tbl[i].e[1]);
    // root 2: oversize pixels get masked down
    set_root(4'd2);
    send('{func: FUNC_START, pixel: 8'h00});
    send('{func: FUNC_PIXEL, pixel: 8'hFF});
    send('{func: FUNC_PIXEL, pixel: 8'hFC});
    send('{func: FUNC_PIXEL, pixel: 8'h03});
    send('{func: FUNC_FINISH, pixel: 8'h00});

    foreach (roots[p]) begin
      // pixels with no start carry on the stream under the root that built it
      rand_stream($urandom_range(1, 3), 1'b1);
      set_root(roots[p]);
      if (p == 9) quiet = 1'b1;
      if (p == 3) long_hold = 1'b1;
      rand_stream($urandom_range(10, 25), 1'b0);
      if (p == 5) drain();
      rand_stream($urandom_range(5, 15), 1'b0);
    end
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("gif_lzw_encoder: match");
    else $display("gif_lzw_encoder: mismatch");
    $finish;
  end

  initial begin
    #10ms;
    $display("gif_lzw_encoder: mismatch");
    $finish;
  end

endmodule
